/* rtl/double_ended_queue_with_dump_assert.svh */
// Assertion macros used by the checker file.
`ifndef DOUBLE_ENDED_QUEUE_WITH_DUMP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_DUMP_ASSERT_SVH

// Clocked check, off while reset is high.
`define DEQ_ASSERT_RST(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Clocked check that also runs through reset.
`define DEQ_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

/* rtl/deq_pkg.sv */
package deq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 3;

  // command queue between the decode and execute sides
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_DEPTH = 1 << CMDQ_AW;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_DUMP       = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    SR_INSERTED = 3'd0,
    SR_DELETED  = 3'd1,
    SR_EMPTY    = 3'd2,
    SR_FULL     = 3'd3,
    SR_LISTED   = 3'd4
  } status_t;

  typedef struct packed {
    func_t                  op;
    logic [DATA_WIDTH-1:0]  value;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] a);
    return (a == ADDR_W'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] a);
    return (a == '0) ? ADDR_W'(DEPTH - 1) : a - 1'b1;
  endfunction

  // a < DEPTH and b <= DEPTH, so one conditional subtract wraps the sum
  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                 input logic [CNT_W-1:0]  b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

/* rtl/deq_if.sv */
interface deq_req_if import deq_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [FUNC_W-1:0]             func;
  logic signed [DATA_WIDTH-1:0]  value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [STATUS_W-1:0]           status;
  logic signed [DATA_WIDTH-1:0]  element;
  logic                          last;

  modport source (output valid, status, element, last, input ready);
  modport sink   (input valid, status, element, last, output ready);
endinterface

/* rtl/deq_ram.sv */
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/deq_front.sv */
module deq_front import deq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  deq_req_if.sink      req,
  output logic         cmd_valid,
  input  logic         cmd_ready,
  output cmd_t         cmd
);

  cmd_t               q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   fill;
  logic               take;
  logic               keep;
  logic               pop;

  assign req.ready = (fill != (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign take      = req.valid && req.ready;
  assign cmd_valid = (fill != '0);
  assign cmd       = q[rd_ptr];
  assign pop       = cmd_valid && cmd_ready;

  // unused function codes are taken and dropped here
  always_comb begin
    case (func_t'(req.func))
      FN_PUSH_FRONT, FN_PUSH_BACK, FN_POP_FRONT, FN_POP_BACK, FN_DUMP: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take && keep) begin
      q[wr_ptr] <= '{op: func_t'(req.func), value: req.value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (take && keep) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (CMDQ_AW + 1)'(take && keep) - (CMDQ_AW + 1)'(pop);
    end
  end

endmodule

/* rtl/deq_back.sv */
module deq_back import deq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_valid,
  output logic         cmd_ready,
  input  cmd_t         cmd,
  deq_rsp_if.source    rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t              state, state_next;
  logic [ADDR_W-1:0]   front_index, front_index_next;
  logic [CNT_W-1:0]    entry_count, entry_count_next;
  logic [ADDR_W-1:0]   rd_addr, rd_addr_next;
  logic [CNT_W-1:0]    dump_idx, dump_idx_next;

  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                  ovalid;
  status_t               ostatus;
  logic [DATA_WIDTH-1:0] oelement;
  logic                  olast;

  logic                  adv, fire, is_full, is_empty, dump_last;
  logic                  load;
  status_t               ld_status;
  logic [DATA_WIDTH-1:0] ld_element;
  logic                  ld_last;

  deq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign adv       = !ovalid || rsp.ready;
  assign cmd_ready = (state == S_IDLE) && adv;
  assign fire      = cmd_valid && cmd_ready;
  assign is_full   = (entry_count == CNT_W'(DEPTH));
  assign is_empty  = (entry_count == '0);
  assign dump_last = (dump_idx == entry_count - 1'b1);

  always_comb begin
    state_next       = state;
    front_index_next = front_index;
    entry_count_next = entry_count;
    rd_addr_next     = rd_addr;
    dump_idx_next    = dump_idx;
    ram_we           = 1'b0;
    ram_waddr        = ring_add(front_index, entry_count);
    ram_re           = 1'b0;
    ram_raddr        = rd_addr;
    load             = 1'b0;
    ld_status        = SR_INSERTED;
    ld_element       = '0;
    ld_last          = 1'b1;

    case (state)
      S_IDLE: begin
        if (fire) begin
          case (cmd.op)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
              load = 1'b1;
              if (is_full) begin
                ld_status = SR_FULL;
              end else begin
                ld_status        = SR_INSERTED;
                ram_we           = 1'b1;
                entry_count_next = entry_count + 1'b1;
                if (cmd.op == FN_PUSH_FRONT) begin
                  ram_waddr        = ring_dec(front_index);
                  front_index_next = ring_dec(front_index);
                end
              end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
              load = 1'b1;
              if (is_empty) begin
                ld_status = SR_EMPTY;
              end else begin
                ld_status        = SR_DELETED;
                entry_count_next = entry_count - 1'b1;
                if (cmd.op == FN_POP_FRONT) begin
                  front_index_next = ring_inc(front_index);
                end
              end
            end
            FN_DUMP: begin
              if (is_empty) begin
                load      = 1'b1;
                ld_status = SR_EMPTY;
              end else begin
                // prefetch the front entry; it shows up in ram_rdata next cycle
                ram_re        = 1'b1;
                ram_raddr     = front_index;
                rd_addr_next  = ring_inc(front_index);
                dump_idx_next = '0;
                state_next    = S_DUMP;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      S_DUMP: begin
        // read data holds while the output is stalled (no read enable)
        if (adv) begin
          load       = 1'b1;
          ld_status  = SR_LISTED;
          ld_element = ram_rdata;
          ld_last    = dump_last;
          if (dump_last) begin
            state_next = S_IDLE;
          end else begin
            ram_re        = 1'b1;
            rd_addr_next  = ring_inc(rd_addr);
            dump_idx_next = dump_idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_index <= '0;
      entry_count <= '0;
      ovalid      <= 1'b0;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      entry_count <= entry_count_next;
      if (load) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr  <= rd_addr_next;
    dump_idx <= dump_idx_next;
    if (load) begin
      ostatus  <= ld_status;
      oelement <= ld_element;
      olast    <= ld_last;
    end
  end

  assign rsp.valid   = ovalid;
  assign rsp.status  = ostatus;
  assign rsp.element = oelement;
  assign rsp.last    = olast;

endmodule

/* rtl/double_ended_queue_with_dump.sv */
// Double-ended queue of signed words with a dump command.
// req channel: func (push front, push back, pop front, pop back, dump) and
// value (used by pushes). Unused func codes are taken and produce nothing.
// rsp channel: status, element, last. Every push or pop gives one item with
// last set; a dump gives one listed item per stored element, front to back,
// last set on the final one, or a single empty-status item.
// A two-entry command queue sits between the request decode and the
// executing side, so requests keep coming in while a result waits.
// A push/pop result passes through the command queue and the output register;
// a dump's elements also pass through the registered RAM read, then come one per cycle while rsp.ready is high.
// Throughput: one push or pop per cycle while rsp.ready is high; a dump holds
// the executing side until its last element is loaded, paced by the single
// registered read port of the element RAM.
// Reset (rst, synchronous): queue emptied, front index zero, command queue
// emptied and output valid cleared. RAM contents are not cleared.
// When rsp.ready is low the output register holds its item; the command
// queue fills and then req.ready drops.
module double_ended_queue_with_dump import deq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  deq_req_if.sink    req,
  deq_rsp_if.source  rsp
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  deq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  deq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp       (rsp)
  );

endmodule

/* rtl/deq_checker.sv */
`include "double_ended_queue_with_dump_assert.svh"

module deq_checker import deq_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [STATUS_W-1:0]    rsp_status,
  input logic [DATA_WIDTH-1:0]  rsp_element,
  input logic                   rsp_last
);

  `DEQ_ASSERT_RST(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_status, rsp_element, rsp_last}), "stalled rsp item changed")
  `DEQ_ASSERT_RST(a_elem_zero, clk, rst, rsp_valid && (rsp_status != SR_LISTED) |-> (rsp_element == '0), "element nonzero on status item")
  `DEQ_ASSERT_RST(a_status_last, clk, rst, rsp_valid && (rsp_status != SR_LISTED) |-> rsp_last, "status item without last")
  `DEQ_ASSERT_ALWAYS(a_reset_quiet, clk, $past(rst) |-> !rsp_valid, "rsp valid right after reset")

endmodule

bind double_ended_queue_with_dump deq_checker u_deq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_element (rsp.element),
  .rsp_last    (rsp.last)
);

/* bench/tb_double_ended_queue_with_dump.sv */
module tb_double_ended_queue_with_dump;
  import deq_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_HOLD    = 80;

  localparam logic [FUNC_W-1:0] FN_UNUSED_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_LAST  = 3'd7;

  localparam logic [DATA_WIDTH-1:0] MOST_POSITIVE = 32'h7fff_ffff;
  localparam logic [DATA_WIDTH-1:0] MOST_NEGATIVE = 32'h8000_0000;

  typedef struct {
    status_t               status;
    logic [DATA_WIDTH-1:0] element;
    logic                  last;
  } deq_result_t;

  // Tracks the ring contents and the results each request should produce.
  class deque_tracker;
    logic [DATA_WIDTH-1:0] ring [DEPTH];
    int unsigned           head;
    int unsigned           count;
    int unsigned           errors;
    deq_result_t           expected_results [$];

    function new();
      head   = 0;
      count  = 0;
      errors = 0;
    endfunction

    function void add_result(status_t s, logic [DATA_WIDTH-1:0] e, logic l);
      deq_result_t r;
      r.status  = s;
      r.element = e;
      r.last    = l;
      expected_results.push_back(r);
    endfunction

    function void note_request(logic [FUNC_W-1:0] f, logic [DATA_WIDTH-1:0] v);
      case (f)
        FN_PUSH_FRONT, FN_PUSH_BACK: begin
          if (count == DEPTH) begin
            add_result(SR_FULL, '0, 1'b1);
          end else begin
            if (f == FN_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              ring[head] = v;
            end else begin
              ring[(head + count) % DEPTH] = v;
            end
            count++;
            add_result(SR_INSERTED, '0, 1'b1);
          end
        end
        FN_POP_FRONT, FN_POP_BACK: begin
          if (count == 0) begin
            add_result(SR_EMPTY, '0, 1'b1);
          end else begin
            if (f == FN_POP_FRONT) begin
              head = (head + 1) % DEPTH;
            end
            count--;
            add_result(SR_DELETED, '0, 1'b1);
          end
        end
        FN_DUMP: begin
          if (count == 0) begin
            add_result(SR_EMPTY, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < count; i++) begin
              add_result(SR_LISTED, ring[(head + i) % DEPTH], i + 1 == count);
            end
          end
        end
        default: begin
          // unused codes are swallowed with no result
        end
      endcase
    endfunction

    function void check_result(logic [STATUS_W-1:0] s, logic [DATA_WIDTH-1:0] e, logic l);
      deq_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual status %0d element %0h last %0b",
                 $time, s, e, l);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (s !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, s);
        errors++;
      end
      if (e !== want.element) begin
        $display("%0t: element mismatch: expected %0h, actual %0h", $time, want.element, e);
        errors++;
      end
      if (l !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, l);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         idle_on = 1'b1;
  logic         hold_request = 1'b0;
  int unsigned  cycles = 0;
  deque_tracker tracker;

  deq_req_if req();
  deq_rsp_if rsp();

  double_ended_queue_with_dump dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [FUNC_W-1:0] random_func(int unsigned push_w, int unsigned pop_w);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_w) begin
      return $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
    end else if (r < push_w + pop_w) begin
      return $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
    end else if (r < 97) begin
      return FN_DUMP;
    end
    return FUNC_W'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
  endfunction

  function automatic logic [DATA_WIDTH-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return MOST_POSITIVE;
      1:       return MOST_NEGATIVE;
      2:       return '0;
      default: return $urandom();
    endcase
  endfunction

  // valid stays up into the next call unless an idle burst drops it
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [DATA_WIDTH-1:0] v);
    req.valid <= 1'b1;
    req.func  <= f;
    req.value <= v;
    do @(posedge clk); while (!req.ready);
    tracker.note_request(f, v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic pause_until_drained();
    req.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int unsigned off_left;
    off_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        tracker.check_result(rsp.status, rsp.element, rsp.last);
      end
      if (off_left == 0) begin
        if (hold_request) begin
          hold_request = 1'b0;
          off_left = LONG_HOLD;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
          off_left = $urandom_range(1, 3);
        end
      end
      if (off_left != 0) begin
        rsp.ready <= 1'b0;
        off_left--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    tracker = new();
    rst       <= 1'b1;
    req.valid <= 1'b0;
    req.func  <= '0;
    req.value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty store: dump and both pops report empty, then pushes, dumps, unused codes and pops
    send_item(FN_DUMP, random_value());
    send_item(FN_POP_FRONT, random_value());
    send_item(FN_POP_BACK, random_value());
    send_item(FN_PUSH_FRONT, MOST_POSITIVE);
    send_item(FN_PUSH_BACK, MOST_NEGATIVE);
    send_item(FN_PUSH_FRONT, '0);
    send_item(FN_PUSH_BACK, '1);
    send_item(FN_PUSH_FRONT, 32'd1);
    send_item(FN_DUMP, random_value());
    send_item(FN_UNUSED_FIRST, random_value());
    send_item(FN_UNUSED_FIRST + 3'd1, random_value());
    send_item(FN_UNUSED_LAST, random_value());
    send_item(FN_POP_FRONT, random_value());
    send_item(FN_POP_BACK, random_value());
    send_item(FN_DUMP, random_value());
    send_item(FN_PUSH_BACK, 32'h5555_5555);
    send_item(FN_PUSH_FRONT, 32'haaaa_aaaa);
    send_item(FN_DUMP, random_value());
    send_item(FN_POP_BACK, random_value());
    send_item(FN_POP_FRONT, random_value());
    pause_until_drained();

    // fill to full while the receiver holds off for a long stretch
    hold_request = 1'b1;
    while (tracker.count < DEPTH) send_item(random_func(85, 8), random_value());
    repeat (3) send_item($urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT, random_value());
    send_item(FN_DUMP, random_value());

    // drain to empty, then poke the empty store
    while (tracker.count > 0) send_item(random_func(8, 85), random_value());
    send_item(FN_POP_FRONT, random_value());
    send_item(FN_POP_BACK, random_value());
    send_item(FN_DUMP, random_value());
    pause_until_drained();

    idle_on = 1'b0;
    repeat (90) send_item(random_func(45, 40), random_value());
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
